FILE: rtl/hpt_pkg.sv
// hpt_pkg: shared types and codes for the harq process table
// holds the command and process-state codes, the table entry layout and the sequencer states
// no dependencies
package hpt_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ACK   = 2'd1,
    CMD_NACK  = 2'd2,
    CMD_RETX  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    PS_IDLE = 2'd0,
    PS_WAIT = 2'd1,
    PS_NACK = 2'd2
  } proc_st_t;

  typedef struct packed {
    proc_st_t   st;
    logic [3:0] cnt;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{st: PS_IDLE, cnt: 4'd0};

  localparam logic [3:0] MAX_RETX_RESET = 4'd4;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_READ,
    SQ_UPD,
    SQ_SCAN,
    SQ_TAIL,
    SQ_DONE
  } seq_st_t;

endpackage

FILE: rtl/hpt_entry_ram.sv
// hpt_entry_ram: process entry store, one write and one registered read per cycle
// per-entry valid flags make unwritten entries read as idle with zero count
// depends on hpt_pkg
module hpt_entry_ram
  import hpt_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t             mem [DEPTH];
  logic   [DEPTH-1:0] vld_r;
  entry_t             rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // a read in a write cycle returns the old entry; the caller never uses it
  always_ff @(posedge clk) begin
    if (vld_r[rd_addr]) begin
      rd_data_r <= mem[rd_addr];
    end else begin
      rd_data_r <= ENTRY_RESET;
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/harq_process_table.sv
// harq_process_table: top level of the harq stop-and-wait process table
// sequencer, entry update and summary scan around one entry store
// depends on hpt_pkg and hpt_entry_ram
//
// Each request names a command and a process. The block reads the process entry,
// applies the command, writes it back, then walks the whole table one entry per
// cycle through the single read port to find the lowest idle process and any
// nacked one. A request for an out-of-range process skips the read and update
// and goes straight to the scan. in_ready is low while a request is in work.
// The result sits in an output register, so the next request is taken while it
// waits; a further result holds until the previous one is taken. max_retx is
// written through cfg_wr_en/cfg_wr_data; the user must do so only while no
// request is in work, which the block does not enforce. It resets to 4. The
// table reads as all idle with zero counts after reset.
module harq_process_table
  import hpt_pkg::*;
#(
  parameter int NUM_PROCS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_pid,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_accepted,
  output logic       out_flushed,
  output logic [1:0] out_proc_state,
  output logic [3:0] out_retx_count,
  output logic       out_idle_found,
  output logic [3:0] out_idle_pid,
  output logic       out_any_nacked
);

  localparam int IW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CW = $clog2(NUM_PROCS + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(NUM_PROCS - 1);
  localparam logic [8:0]    PID_LIM  = 9'(NUM_PROCS);

  seq_st_t        sq_r, sq_nxt;
  logic [3:0]     max_retx_r;
  cmd_t           cmd_r;
  logic [7:0]     pid_r;
  logic [CW-1:0]  scan_idx_r, scan_idx_nxt;
  logic [IW-1:0]  tag_r, tag_nxt;
  logic           have_r, have_nxt;

  logic           acc_r, acc_nxt;
  logic           fl_r, fl_nxt;
  proc_st_t       st_r, st_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic           found_r, found_nxt;
  logic [3:0]     ipid_r, ipid_nxt;
  logic           nacked_r, nacked_nxt;

  logic           out_valid_r, out_valid_nxt;
  logic           o_acc_r, o_fl_r, o_found_r, o_nacked_r;
  proc_st_t       o_st_r;
  logic [3:0]     o_cnt_r, o_ipid_r;
  logic           load_out;

  logic           ram_we;
  logic [IW-1:0]  ram_rd_addr;
  entry_t         ram_rd_data;
  entry_t         upd_entry;
  logic           upd_acc, upd_fl;
  logic [4:0]     inc;

  hpt_entry_ram #(
    .DEPTH (NUM_PROCS),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (ram_we),
    .wr_addr (pid_r[IW-1:0]),
    .wr_data (upd_entry),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // command applied to the entry read back for the addressed process
  always_comb begin
    upd_entry = ram_rd_data;
    upd_acc   = 1'b0;
    upd_fl    = 1'b0;
    inc       = {1'b0, ram_rd_data.cnt} + 5'd1;
    unique case (cmd_r)
      CMD_START: begin
        if (ram_rd_data.st == PS_IDLE) begin
          upd_entry.st  = PS_WAIT;
          upd_entry.cnt = 4'd0;
          upd_acc       = 1'b1;
        end
      end
      CMD_ACK: begin
        upd_entry = ENTRY_RESET;
      end
      CMD_NACK: begin
        if (ram_rd_data.st == PS_WAIT) begin
          upd_entry.st = PS_NACK;
        end
      end
      CMD_RETX: begin
        if (ram_rd_data.st == PS_NACK) begin
          if (inc > {1'b0, max_retx_r}) begin
            upd_entry = ENTRY_RESET;
            upd_fl    = 1'b1;
          end else begin
            upd_entry.st  = PS_WAIT;
            upd_entry.cnt = inc[3:0];
            upd_acc       = 1'b1;
          end
        end
      end
      default: begin
        upd_entry = ram_rd_data;
      end
    endcase
  end

  always_comb begin
    sq_nxt        = sq_r;
    scan_idx_nxt  = scan_idx_r;
    tag_nxt       = tag_r;
    have_nxt      = have_r;
    acc_nxt       = acc_r;
    fl_nxt        = fl_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    ipid_nxt      = ipid_r;
    nacked_nxt    = nacked_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_rd_addr   = pid_r[IW-1:0];
    load_out      = 1'b0;
    in_ready      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // summary from the entry read in the previous scan cycle
    if ((sq_r == SQ_SCAN && have_r) || sq_r == SQ_TAIL) begin
      if (!found_r && ram_rd_data.st == PS_IDLE) begin
        found_nxt = 1'b1;
        ipid_nxt  = 4'(tag_r);
      end
      if (ram_rd_data.st == PS_NACK) begin
        nacked_nxt = 1'b1;
      end
    end

    unique case (sq_r)
      SQ_IDLE: begin
        // no request is taken while reset is held
        in_ready     = rst_n;
        acc_nxt      = 1'b0;
        fl_nxt       = 1'b0;
        st_nxt       = PS_IDLE;
        cnt_nxt      = 4'd0;
        found_nxt    = 1'b0;
        ipid_nxt     = 4'd0;
        nacked_nxt   = 1'b0;
        scan_idx_nxt = '0;
        have_nxt     = 1'b0;
        if (in_valid) begin
          if ({1'b0, in_pid} < PID_LIM) begin
            sq_nxt = SQ_READ;
          end else begin
            sq_nxt = SQ_SCAN;
          end
        end
      end
      SQ_READ: begin
        sq_nxt = SQ_UPD;
      end
      SQ_UPD: begin
        ram_we  = 1'b1;
        acc_nxt = upd_acc;
        fl_nxt  = upd_fl;
        st_nxt  = upd_entry.st;
        cnt_nxt = upd_entry.cnt;
        sq_nxt  = SQ_SCAN;
      end
      SQ_SCAN: begin
        ram_rd_addr  = scan_idx_r[IW-1:0];
        tag_nxt      = scan_idx_r[IW-1:0];
        have_nxt     = 1'b1;
        scan_idx_nxt = scan_idx_r + CW'(1);
        if (scan_idx_r == LAST_IDX) begin
          sq_nxt = SQ_TAIL;
        end
      end
      SQ_TAIL: begin
        sq_nxt = SQ_DONE;
      end
      SQ_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          sq_nxt        = SQ_IDLE;
        end
      end
      default: begin
        sq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= SQ_IDLE;
      out_valid_r <= 1'b0;
      max_retx_r  <= MAX_RETX_RESET;
    end else begin
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_retx_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sq_r == SQ_IDLE && in_valid) begin
      cmd_r <= cmd_t'(in_cmd);
      pid_r <= in_pid;
    end
    scan_idx_r <= scan_idx_nxt;
    tag_r      <= tag_nxt;
    have_r     <= have_nxt;
    acc_r      <= acc_nxt;
    fl_r       <= fl_nxt;
    st_r       <= st_nxt;
    cnt_r      <= cnt_nxt;
    found_r    <= found_nxt;
    ipid_r     <= ipid_nxt;
    nacked_r   <= nacked_nxt;
    if (load_out) begin
      o_acc_r    <= acc_r;
      o_fl_r     <= fl_r;
      o_st_r     <= st_r;
      o_cnt_r    <= cnt_r;
      o_found_r  <= found_r;
      o_ipid_r   <= ipid_r;
      o_nacked_r <= nacked_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = o_acc_r;
  assign out_flushed    = o_fl_r;
  assign out_proc_state = o_st_r;
  assign out_retx_count = o_cnt_r;
  assign out_idle_found = o_found_r;
  assign out_idle_pid   = o_ipid_r;
  assign out_any_nacked = o_nacked_r;

endmodule
